// ===== rtl/core/bat_pkg.sv =====
// Shared types, constants and a helper function for the buddy allocator tree.
`default_nettype none

package bat_pkg;

    localparam int TOTAL_SLOTS = 1024;
    localparam int TREE_NODES  = 2 * TOTAL_SLOTS - 1;
    localparam int IDX_W       = $clog2(TREE_NODES);
    localparam int RUN_W       = $clog2(TOTAL_SLOTS) + 1;
    localparam int CMD_W       = 2;
    localparam int WANT_W      = 11;
    localparam int OFF_W       = 10;
    localparam int NEED_W      = WANT_W + 1;
    localparam int STAT_W      = 3;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOSPACE  = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTALLOC = 3'd4
    } bat_status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_RD_IDX,
        OP_RD_LEFT,
        OP_DESCEND,
        OP_MARK,
        OP_RD_SIB,
        OP_WR_PARENT,
        OP_CLIMB,
        OP_FOUND,
        OP_RELEASE,
        OP_RESULT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ROOT,
        S_DESC,
        S_STEP,
        S_UP,
        S_MERGE,
        S_FIND,
        S_FIND_RD,
        S_HIT
    } ctl_state_t;

    typedef struct packed {
        dp_op_t      op;
        bat_status_t code;
    } dp_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             want_zero;
        logic             need_big;
        logic             off_range;
        logic             rd_short;
        logic             rd_zero;
        logic             at_need;
        logic             at_root;
        logic             clr_last;
    } dp_sts_t;

    // Rounds a request up to the next power of two.
    function automatic logic [NEED_W-1:0] ceil_pow2(input logic [WANT_W-1:0] want);
        logic [WANT_W-1:0] wm1;
        logic [3:0]        pos;
        wm1 = want - WANT_W'(1);
        pos = 4'd0;
        for (int i = 0; i < WANT_W; i++)
        begin
            if (wm1[i])
            begin
                pos = 4'(i + 1);
            end
        end
        if (want <= WANT_W'(1))
        begin
            pos = 4'd0;
        end
        return NEED_W'(1) << pos;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bat_datapath.sv =====
// Datapath of the buddy allocator: the run tree memory, walk registers and result registers.
`default_nettype none

module bat_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [bat_pkg::CMD_W-1:0]      cmd,
    input  wire logic [bat_pkg::WANT_W-1:0]     slots_wanted,
    input  wire logic [bat_pkg::OFF_W-1:0]      slot_offset,
    input  wire bat_pkg::dp_ctl_t               ctl,
    output bat_pkg::dp_sts_t                    sts,
    output logic                                done,
    output logic [bat_pkg::STAT_W-1:0]          status,
    output logic [bat_pkg::OFF_W-1:0]           granted_offset,
    output logic [bat_pkg::RUN_W-1:0]           block_slots
);

    logic [bat_pkg::RUN_W-1:0]  run_mem [bat_pkg::TREE_NODES];

    logic [bat_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [bat_pkg::RUN_W-1:0]  sz_reg, sz_next;
    logic [bat_pkg::RUN_W-1:0]  cur_reg, cur_next;
    logic [bat_pkg::RUN_W-1:0]  blk_reg, blk_next;
    logic [bat_pkg::OFF_W-1:0]  gofs_reg, gofs_next;
    logic [bat_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [bat_pkg::WANT_W-1:0] want_reg, want_next;
    logic [bat_pkg::OFF_W-1:0]  off_reg, off_next;
    logic [bat_pkg::NEED_W-1:0] need_reg, need_next;
    logic [bat_pkg::RUN_W-1:0]  rd_data_reg;

    logic                       done_reg, done_next;
    logic [bat_pkg::STAT_W-1:0] status_reg, status_next;
    logic [bat_pkg::OFF_W-1:0]  granted_reg, granted_next;
    logic [bat_pkg::RUN_W-1:0]  blocks_reg, blocks_next;

    logic                       rd_en;
    logic [bat_pkg::IDX_W-1:0]  rd_addr;
    logic                       wr_en;
    logic [bat_pkg::IDX_W-1:0]  wr_addr;
    logic [bat_pkg::RUN_W-1:0]  wr_data;

    logic [bat_pkg::IDX_W-1:0]  left_idx;
    logic [bat_pkg::IDX_W-1:0]  parent_idx;
    logic [bat_pkg::IDX_W-1:0]  sib_idx;
    logic [bat_pkg::IDX_W-1:0]  leaf_idx;
    logic [bat_pkg::IDX_W:0]    clr_n;
    logic [bat_pkg::RUN_W-1:0]  psz;
    logic [bat_pkg::RUN_W:0]    pair_sum;
    logic [bat_pkg::RUN_W-1:0]  pair_max;
    logic [bat_pkg::RUN_W-1:0]  merged;

    always_comb
    begin
        left_idx   = bat_pkg::IDX_W'({idx_reg, 1'b1});
        parent_idx = (idx_reg - bat_pkg::IDX_W'(1)) >> 1;
        sib_idx    = idx_reg[0] ? idx_reg + bat_pkg::IDX_W'(1) : idx_reg - bat_pkg::IDX_W'(1);
        leaf_idx   = bat_pkg::IDX_W'(slot_offset) + bat_pkg::IDX_W'(bat_pkg::TOTAL_SLOTS - 1);
        clr_n      = {1'b0, idx_reg} + (bat_pkg::IDX_W + 1)'(2);
        psz        = sz_reg << 1;
        pair_sum   = {1'b0, cur_reg} + {1'b0, rd_data_reg};
        pair_max   = (cur_reg > rd_data_reg) ? cur_reg : rd_data_reg;
        if (cmd_reg == bat_pkg::CMD_FREE && pair_sum == {1'b0, psz})
        begin
            merged = psz;
        end
        else
        begin
            merged = pair_max;
        end
    end

    always_comb
    begin
        sts.cmd       = cmd_reg;
        sts.want_zero = (want_reg == '0);
        sts.need_big  = (need_reg > bat_pkg::NEED_W'(bat_pkg::TOTAL_SLOTS));
        sts.off_range = ({1'b0, off_reg} >= (bat_pkg::OFF_W + 1)'(bat_pkg::TOTAL_SLOTS));
        sts.rd_short  = ({1'b0, rd_data_reg} < need_reg);
        sts.rd_zero   = (rd_data_reg == '0);
        sts.at_need   = ({1'b0, sz_reg} == need_reg);
        sts.at_root   = (idx_reg == '0);
        sts.clr_last  = (idx_reg == bat_pkg::IDX_W'(bat_pkg::TREE_NODES - 1));
    end

    always_comb
    begin
        idx_next     = idx_reg;
        sz_next      = sz_reg;
        cur_next     = cur_reg;
        blk_next     = blk_reg;
        gofs_next    = gofs_reg;
        cmd_next     = cmd_reg;
        want_next    = want_reg;
        off_next     = off_reg;
        need_next    = need_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        granted_next = granted_reg;
        blocks_next  = blocks_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = sz_reg;
        case (ctl.op)
            bat_pkg::OP_CLR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_reg + bat_pkg::IDX_W'(1);
                if ((clr_n & (clr_n - (bat_pkg::IDX_W + 1)'(1))) == '0)
                begin
                    sz_next = sz_reg >> 1;
                end
            end
            bat_pkg::OP_LOAD:
            begin
                cmd_next  = cmd;
                want_next = slots_wanted;
                off_next  = slot_offset;
                need_next = bat_pkg::ceil_pow2(slots_wanted);
                gofs_next = '0;
                blk_next  = '0;
                if (cmd == bat_pkg::CMD_ALLOC)
                begin
                    idx_next = '0;
                    sz_next  = bat_pkg::RUN_W'(bat_pkg::TOTAL_SLOTS);
                end
                else
                begin
                    idx_next = leaf_idx;
                    sz_next  = bat_pkg::RUN_W'(1);
                end
            end
            bat_pkg::OP_RD_IDX:
            begin
                rd_en = 1'b1;
            end
            bat_pkg::OP_RD_LEFT:
            begin
                rd_en   = 1'b1;
                rd_addr = left_idx;
            end
            bat_pkg::OP_DESCEND:
            begin
                sz_next = sz_reg >> 1;
                if ({1'b0, rd_data_reg} >= need_reg)
                begin
                    idx_next = left_idx;
                end
                else
                begin
                    idx_next  = left_idx + bat_pkg::IDX_W'(1);
                    gofs_next = gofs_reg + bat_pkg::OFF_W'(sz_reg >> 1);
                end
            end
            bat_pkg::OP_MARK:
            begin
                wr_en    = 1'b1;
                wr_data  = '0;
                cur_next = '0;
            end
            bat_pkg::OP_RD_SIB:
            begin
                rd_en   = 1'b1;
                rd_addr = sib_idx;
            end
            bat_pkg::OP_WR_PARENT:
            begin
                wr_en    = 1'b1;
                wr_addr  = parent_idx;
                wr_data  = merged;
                cur_next = merged;
                idx_next = parent_idx;
                sz_next  = psz;
            end
            bat_pkg::OP_CLIMB:
            begin
                idx_next = parent_idx;
                sz_next  = psz;
            end
            bat_pkg::OP_FOUND:
            begin
                blk_next = sz_reg;
            end
            bat_pkg::OP_RELEASE:
            begin
                wr_en    = 1'b1;
                cur_next = sz_reg;
            end
            bat_pkg::OP_RESULT:
            begin
                done_next    = 1'b1;
                status_next  = ctl.code;
                granted_next = '0;
                blocks_next  = '0;
                if (ctl.code == bat_pkg::ST_OK)
                begin
                    case (cmd_reg)
                        bat_pkg::CMD_ALLOC:
                        begin
                            granted_next = gofs_reg;
                            blocks_next  = need_reg[bat_pkg::RUN_W-1:0];
                        end
                        bat_pkg::CMD_FREE, bat_pkg::CMD_QUERY:
                        begin
                            blocks_next = blk_reg;
                        end
                        default:
                        begin
                            blocks_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            run_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= run_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            sz_reg   <= bat_pkg::RUN_W'(bat_pkg::TOTAL_SLOTS);
            done_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            sz_reg   <= sz_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        blk_reg     <= blk_next;
        gofs_reg    <= gofs_next;
        cmd_reg     <= cmd_next;
        want_reg    <= want_next;
        off_reg     <= off_next;
        need_reg    <= need_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        blocks_reg  <= blocks_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign granted_offset = granted_reg;
    assign block_slots    = blocks_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bat_ctrl.sv =====
// Controller state machine that sequences the tree walks of the buddy allocator.
`default_nettype none

module bat_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bat_pkg::dp_sts_t  sts,
    output bat_pkg::dp_ctl_t       ctl
);

    bat_pkg::ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bat_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = bat_pkg::OP_NONE;
        ctl.code   = bat_pkg::ST_OK;
        busy       = 1'b1;
        case (state_reg)
            bat_pkg::S_CLEAR:
            begin
                ctl.op = bat_pkg::OP_CLR;
                if (sts.clr_last)
                begin
                    state_next = bat_pkg::S_IDLE;
                end
            end
            bat_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.op     = bat_pkg::OP_LOAD;
                    state_next = bat_pkg::S_DECODE;
                end
            end
            bat_pkg::S_DECODE:
            begin
                case (sts.cmd)
                    bat_pkg::CMD_ALLOC:
                    begin
                        if (sts.want_zero)
                        begin
                            ctl.op     = bat_pkg::OP_RESULT;
                            ctl.code   = bat_pkg::ST_ZERO;
                            state_next = bat_pkg::S_IDLE;
                        end
                        else if (sts.need_big)
                        begin
                            ctl.op     = bat_pkg::OP_RESULT;
                            ctl.code   = bat_pkg::ST_NOSPACE;
                            state_next = bat_pkg::S_IDLE;
                        end
                        else
                        begin
                            ctl.op     = bat_pkg::OP_RD_IDX;
                            state_next = bat_pkg::S_ROOT;
                        end
                    end
                    bat_pkg::CMD_FREE, bat_pkg::CMD_QUERY:
                    begin
                        if (sts.off_range)
                        begin
                            ctl.op     = bat_pkg::OP_RESULT;
                            ctl.code   = bat_pkg::ST_RANGE;
                            state_next = bat_pkg::S_IDLE;
                        end
                        else
                        begin
                            ctl.op     = bat_pkg::OP_RD_IDX;
                            state_next = bat_pkg::S_FIND;
                        end
                    end
                    default:
                    begin
                        ctl.op     = bat_pkg::OP_RESULT;
                        state_next = bat_pkg::S_IDLE;
                    end
                endcase
            end
            bat_pkg::S_ROOT:
            begin
                if (sts.rd_short)
                begin
                    ctl.op     = bat_pkg::OP_RESULT;
                    ctl.code   = bat_pkg::ST_NOSPACE;
                    state_next = bat_pkg::S_IDLE;
                end
                else if (sts.at_need)
                begin
                    ctl.op     = bat_pkg::OP_MARK;
                    state_next = bat_pkg::S_UP;
                end
                else
                begin
                    ctl.op     = bat_pkg::OP_RD_LEFT;
                    state_next = bat_pkg::S_DESC;
                end
            end
            bat_pkg::S_DESC:
            begin
                ctl.op     = bat_pkg::OP_DESCEND;
                state_next = bat_pkg::S_STEP;
            end
            bat_pkg::S_STEP:
            begin
                if (sts.at_need)
                begin
                    ctl.op     = bat_pkg::OP_MARK;
                    state_next = bat_pkg::S_UP;
                end
                else
                begin
                    ctl.op     = bat_pkg::OP_RD_LEFT;
                    state_next = bat_pkg::S_DESC;
                end
            end
            bat_pkg::S_UP:
            begin
                if (sts.at_root)
                begin
                    ctl.op     = bat_pkg::OP_RESULT;
                    state_next = bat_pkg::S_IDLE;
                end
                else
                begin
                    ctl.op     = bat_pkg::OP_RD_SIB;
                    state_next = bat_pkg::S_MERGE;
                end
            end
            bat_pkg::S_MERGE:
            begin
                ctl.op     = bat_pkg::OP_WR_PARENT;
                state_next = bat_pkg::S_UP;
            end
            bat_pkg::S_FIND:
            begin
                if (sts.rd_zero)
                begin
                    ctl.op     = bat_pkg::OP_FOUND;
                    state_next = bat_pkg::S_HIT;
                end
                else if (sts.at_root)
                begin
                    ctl.op     = bat_pkg::OP_RESULT;
                    ctl.code   = bat_pkg::ST_NOTALLOC;
                    state_next = bat_pkg::S_IDLE;
                end
                else
                begin
                    ctl.op     = bat_pkg::OP_CLIMB;
                    state_next = bat_pkg::S_FIND_RD;
                end
            end
            bat_pkg::S_FIND_RD:
            begin
                ctl.op     = bat_pkg::OP_RD_IDX;
                state_next = bat_pkg::S_FIND;
            end
            bat_pkg::S_HIT:
            begin
                if (sts.cmd == bat_pkg::CMD_FREE)
                begin
                    ctl.op     = bat_pkg::OP_RELEASE;
                    state_next = bat_pkg::S_UP;
                end
                else
                begin
                    ctl.op     = bat_pkg::OP_RESULT;
                    state_next = bat_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bat_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/buddy_allocator_tree_top.sv =====
// Top level of the buddy allocator tree: controller and datapath.
// Decode settles invalid requests; otherwise allocate reads the root, fails if it lacks space, else
// descends level by level and updates the runs back up to the root; free and query climb from the
// leaf to the block, and free then merges up. Each level reads through the tree's single read port.
// One request is in flight at a time; the next is accepted as done shows; done cannot stall.
// After reset the block sweeps the 2047-entry run tree with busy high.
`default_nettype none

module buddy_allocator_tree_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [bat_pkg::CMD_W-1:0]   cmd,
    input  wire logic [bat_pkg::WANT_W-1:0]  slots_wanted,
    input  wire logic [bat_pkg::OFF_W-1:0]   slot_offset,
    output logic                             done,
    output logic [bat_pkg::STAT_W-1:0]       status,
    output logic [bat_pkg::OFF_W-1:0]        granted_offset,
    output logic [bat_pkg::RUN_W-1:0]        block_slots
);

    bat_pkg::dp_ctl_t ctl;
    bat_pkg::dp_sts_t sts;

    bat_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    bat_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .slots_wanted   (slots_wanted),
        .slot_offset    (slot_offset),
        .ctl            (ctl),
        .sts            (sts),
        .done           (done),
        .status         (status),
        .granted_offset (granted_offset),
        .block_slots    (block_slots)
    );

endmodule

`default_nettype wire

// ===== rtl/core/bat_checker.sv =====
// Port-level checker for the buddy allocator tree and its bind to the top level.
`default_nettype none

module bat_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        done,
    input wire logic [bat_pkg::STAT_W-1:0]  status,
    input wire logic [bat_pkg::OFF_W-1:0]   granted_offset,
    input wire logic [bat_pkg::RUN_W-1:0]   block_slots
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted request");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy ##1 !done)
        else $error("done strobe while busy or longer than one cycle");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != bat_pkg::ST_OK |-> granted_offset == '0 && block_slots == '0)
        else $error("error result carries nonzero fields");

    a_block_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        done && block_slots != '0 |-> $onehot(block_slots))
        else $error("block size is not a power of two");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status == bat_pkg::ST_OK || status == bat_pkg::ST_ZERO
              || status == bat_pkg::ST_NOSPACE || status == bat_pkg::ST_RANGE
              || status == bat_pkg::ST_NOTALLOC)
        else $error("status code out of range");

endmodule

bind buddy_allocator_tree_top bat_checker u_bat_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .granted_offset (granted_offset),
    .block_slots    (block_slots)
);

`default_nettype wire

// ===== tb/buddy_allocator_tree_top_tb.sv =====
// Self-checking testbench for the buddy allocator tree with a built-in tree predictor.
`timescale 1ns / 100ps

module buddy_allocator_tree_top_tb;

    localparam logic [bat_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 750;
    localparam int STALL_LIMIT     = 10000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int REPORT_LIMIT    = 10;

    typedef struct {
        logic [bat_pkg::CMD_W-1:0]  cmd;
        logic [bat_pkg::WANT_W-1:0] want;
        logic [bat_pkg::OFF_W-1:0]  off;
        int                         idle_pct;
    } alloc_req_t;

    typedef struct {
        bat_pkg::bat_status_t       status;
        logic [bat_pkg::OFF_W-1:0]  granted;
        logic [bat_pkg::RUN_W-1:0]  blk;
    } alloc_resp_t;

    typedef struct {
        int base;
        int size;
    } live_block_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [bat_pkg::CMD_W-1:0]   cmd = '0;
    logic [bat_pkg::WANT_W-1:0]  slots_wanted = '0;
    logic [bat_pkg::OFF_W-1:0]   slot_offset = '0;
    logic                        busy;
    logic                        done;
    logic [bat_pkg::STAT_W-1:0]  status;
    logic [bat_pkg::OFF_W-1:0]   granted_offset;
    logic [bat_pkg::RUN_W-1:0]   block_slots;

    alloc_req_t  pending_requests[$];
    alloc_resp_t expected_responses[$];
    live_block_t live_blocks[$];
    logic [bat_pkg::RUN_W-1:0] node_run [bat_pkg::TREE_NODES];

    logic taken = 1'b0;
    int   error_count = 0;
    int   stall_cycles = 0;

    buddy_allocator_tree_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .slots_wanted   (slots_wanted),
        .slot_offset    (slot_offset),
        .done           (done),
        .status         (status),
        .granted_offset (granted_offset),
        .block_slots    (block_slots)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic apply_request(input alloc_req_t rq, output alloc_resp_t rs);
        int need;
        int idx;
        int sz;
        int l;
        int r;
        int base;
        bit found;
        rs.status  = bat_pkg::ST_OK;
        rs.granted = '0;
        rs.blk     = '0;
        if (rq.cmd == bat_pkg::CMD_ALLOC)
        begin
            if (rq.want == 0)
            begin
                rs.status = bat_pkg::ST_ZERO;
            end
            else
            begin
                need = 1;
                while (need < int'(rq.want))
                begin
                    need = need << 1;
                end
                if (need > bat_pkg::TOTAL_SLOTS || int'(node_run[0]) < need)
                begin
                    rs.status = bat_pkg::ST_NOSPACE;
                end
                else
                begin
                    idx = 0;
                    sz = bat_pkg::TOTAL_SLOTS;
                    while (sz != need)
                    begin
                        idx = (int'(node_run[2 * idx + 1]) >= need) ? 2 * idx + 1 : 2 * idx + 2;
                        sz = sz >> 1;
                    end
                    rs.granted = bat_pkg::OFF_W'((idx + 1) * need - bat_pkg::TOTAL_SLOTS);
                    rs.blk = bat_pkg::RUN_W'(need);
                    live_blocks.push_back('{base: (idx + 1) * need - bat_pkg::TOTAL_SLOTS,
                                            size: need});
                    node_run[idx] = '0;
                    while (idx != 0)
                    begin
                        idx = (idx - 1) / 2;
                        l = node_run[2 * idx + 1];
                        r = node_run[2 * idx + 2];
                        node_run[idx] = bat_pkg::RUN_W'((l > r) ? l : r);
                    end
                end
            end
        end
        else if (rq.cmd == bat_pkg::CMD_FREE || rq.cmd == bat_pkg::CMD_QUERY)
        begin
            if (int'(rq.off) >= bat_pkg::TOTAL_SLOTS)
            begin
                rs.status = bat_pkg::ST_RANGE;
            end
            else
            begin
                idx = int'(rq.off) + bat_pkg::TOTAL_SLOTS - 1;
                sz = 1;
                found = 1'b1;
                while (node_run[idx] != 0)
                begin
                    if (idx == 0)
                    begin
                        found = 1'b0;
                        break;
                    end
                    idx = (idx - 1) / 2;
                    sz = sz << 1;
                end
                if (!found)
                begin
                    rs.status = bat_pkg::ST_NOTALLOC;
                end
                else
                begin
                    rs.blk = bat_pkg::RUN_W'(sz);
                    if (rq.cmd == bat_pkg::CMD_FREE)
                    begin
                        base = int'(rq.off) - (int'(rq.off) % sz);
                        for (int i = 0; i < live_blocks.size(); i++)
                        begin
                            if (live_blocks[i].base == base)
                            begin
                                live_blocks.delete(i);
                                break;
                            end
                        end
                        node_run[idx] = bat_pkg::RUN_W'(sz);
                        while (idx != 0)
                        begin
                            idx = (idx - 1) / 2;
                            sz = sz << 1;
                            l = node_run[2 * idx + 1];
                            r = node_run[2 * idx + 2];
                            node_run[idx] = bat_pkg::RUN_W'((l + r == sz) ? sz :
                                                            ((l > r) ? l : r));
                        end
                    end
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || taken)
        begin
            if (pending_requests.size() > 0 &&
                $urandom_range(99) >= pending_requests[0].idle_pct)
            begin
                cmd          <= pending_requests[0].cmd;
                slots_wanted <= pending_requests[0].want;
                slot_offset  <= pending_requests[0].off;
                start        <= 1'b1;
                void'(pending_requests.pop_front());
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        alloc_req_t  rq;
        alloc_resp_t rs;
        alloc_resp_t exp_rsp;
        bit          accept;
        accept = rst_n && start && !busy;
        taken <= accept;
        if (rst_n && done)
        begin
            if (expected_responses.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                begin
                    $display("%0t: result with no request pending: status %0d offset %0d",
                             $time, status, granted_offset);
                    $display("%0t: slots %0d", $time, block_slots);
                end
            end
            else
            begin
                exp_rsp = expected_responses.pop_front();
                if (status !== exp_rsp.status || granted_offset !== exp_rsp.granted ||
                    block_slots !== exp_rsp.blk)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: mismatch: status exp %0d got %0d, offset exp %0d got %0d",
                                 $time, exp_rsp.status, status, exp_rsp.granted,
                                 granted_offset);
                        $display("%0t: mismatch: slots exp %0d got %0d",
                                 $time, exp_rsp.blk, block_slots);
                    end
                end
            end
        end
        if (accept)
        begin
            rq.cmd      = cmd;
            rq.want     = slots_wanted;
            rq.off      = slot_offset;
            rq.idle_pct = 0;
            apply_request(rq, rs);
            expected_responses.push_back(rs);
        end
        if (accept || (rst_n && done))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic push_request(input logic [bat_pkg::CMD_W-1:0] c, input int want,
                                input int off, input int idle_pct);
        alloc_req_t rq;
        rq.cmd      = c;
        rq.want     = bat_pkg::WANT_W'(want);
        rq.off      = bat_pkg::OFF_W'(off);
        rq.idle_pct = idle_pct;
        pending_requests.push_back(rq);
    endtask

    initial
    begin : stimulus
        int level_end;
        int sz;
        int pick;
        int pct;
        int want;
        int off;
        int k;
        level_end = 1;
        sz = bat_pkg::TOTAL_SLOTS;
        for (int i = 0; i < bat_pkg::TREE_NODES; i++)
        begin
            if (i == level_end)
            begin
                sz = sz >> 1;
                level_end = 2 * level_end + 1;
            end
            node_run[i] = bat_pkg::RUN_W'(sz);
        end
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        push_request(bat_pkg::CMD_ALLOC, 0, 0, 0);
        push_request(bat_pkg::CMD_ALLOC, 1, 1023, 0);
        push_request(bat_pkg::CMD_ALLOC, 3, 0, 0);
        push_request(bat_pkg::CMD_ALLOC, 2047, 0, 0);
        push_request(bat_pkg::CMD_ALLOC, 1024, 0, 0);
        push_request(bat_pkg::CMD_ALLOC, 512, 0, 0);
        push_request(bat_pkg::CMD_QUERY, 2047, 6, 0);
        push_request(bat_pkg::CMD_QUERY, 0, 1, 0);
        push_request(bat_pkg::CMD_FREE, 0, 5, 0);
        push_request(bat_pkg::CMD_FREE, 0, 5, 0);
        push_request(CMD_UNUSED, 2047, 1023, 0);
        push_request(bat_pkg::CMD_FREE, 0, 0, 0);
        push_request(bat_pkg::CMD_QUERY, 0, 1023, 0);
        push_request(bat_pkg::CMD_FREE, 0, 700, 0);
        push_request(bat_pkg::CMD_ALLOC, 1024, 0, 0);
        push_request(bat_pkg::CMD_ALLOC, 1, 0, 0);
        push_request(bat_pkg::CMD_QUERY, 0, 1023, 0);
        push_request(bat_pkg::CMD_FREE, 0, 512, 0);
        push_request(bat_pkg::CMD_ALLOC, 513, 0, 0);
        push_request(bat_pkg::CMD_FREE, 0, 1023, 0);
        push_request(bat_pkg::CMD_ALLOC, 2, 0, 0);
        push_request(bat_pkg::CMD_ALLOC, 1025, 0, 0);
        push_request(bat_pkg::CMD_FREE, 0, 0, 0);
        push_request(CMD_UNUSED, 0, 0, 0);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            while (pending_requests.size() > 1)
            begin
                @(posedge clk);
            end
            if (n < RANDOM_REQUESTS / 4)
            begin
                pct = 0;
            end
            else if (n < RANDOM_REQUESTS / 2)
            begin
                pct = 71;
            end
            else if (n < 3 * RANDOM_REQUESTS / 4)
            begin
                pct = 0;
            end
            else
            begin
                pct = 13;
            end
            pick = $urandom_range(99);
            if (live_blocks.size() > 0 && pick < 50)
            begin
                k = $urandom_range(live_blocks.size() - 1);
                off = live_blocks[k].base;
                if ($urandom_range(1) == 1)
                begin
                    off = off + $urandom_range(live_blocks[k].size - 1);
                end
                push_request((pick < 35) ? bat_pkg::CMD_FREE : bat_pkg::CMD_QUERY,
                             $urandom_range(2047), off, pct);
            end
            else if (pick < 55)
            begin
                push_request(bat_pkg::CMD_FREE, $urandom_range(2047), $urandom_range(1023),
                             pct);
            end
            else if (pick < 60)
            begin
                push_request(bat_pkg::CMD_QUERY, $urandom_range(2047), $urandom_range(1023),
                             pct);
            end
            else if (pick < 63)
            begin
                push_request(CMD_UNUSED, $urandom_range(2047), $urandom_range(1023), pct);
            end
            else
            begin
                k = $urandom_range(99);
                if (k < 70)
                begin
                    want = $urandom_range(16, 1);
                end
                else if (k < 90)
                begin
                    want = $urandom_range(128, 1);
                end
                else if (k < 96)
                begin
                    want = $urandom_range(1024, 129);
                end
                else if (k < 98)
                begin
                    want = 0;
                end
                else
                begin
                    want = $urandom_range(2047, 1025);
                end
                push_request(bat_pkg::CMD_ALLOC, want, $urandom_range(1023), pct);
            end
        end

        while (pending_requests.size() != 0 || start)
        begin
            @(posedge clk);
        end
        while (expected_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bat_pkg.sv
rtl/core/bat_datapath.sv
rtl/core/bat_ctrl.sv
rtl/core/buddy_allocator_tree_top.sv
rtl/core/bat_checker.sv
tb/buddy_allocator_tree_top_tb.sv
